[hw/rtl/apc_pkg.sv]
// Shared constants, types and sRGB conversion tables for the arithmetic pixel composite.
package apc_pkg;

    // Coefficient format
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_W         = 24;

    // Pixel layout
    localparam int CODE_W     = 8;
    localparam int LANES      = 4;
    localparam int ALPHA_LANE = 3;
    localparam int PIXEL_W    = LANES * CODE_W;

    // Lane datapath widths
    localparam int PA_W   = COEF_W + CODE_W + 1;     // k1*a
    localparam int S1_W   = PA_W + 1;                // k2*a + k3*b
    localparam int M_W    = PA_W + CODE_W + 1;       // k1*a*b
    localparam int K4_W   = COEF_W + CODE_W + 1;     // 255*k4
    localparam int L1_W   = S1_W + 1;                // k2*a + k3*b + 255*k4
    localparam int L_W    = L1_W + CODE_W + 1;       // 255*(...)
    localparam int NUM_W  = L_W + 1;                 // full numerator
    localparam int T_W    = NUM_W - 1 - COEF_FRAC_BITS;
    localparam int SAT_T  = 255 * 256;               // floor(num/2^F) at or above saturates

    // Pipeline: map, mult 1, mult 2, sum/divide, output
    localparam int STAGES = 5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PRODUCT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SECOND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_MODE  = 3'd4;

    typedef struct packed {
        logic signed [COEF_W-1:0] k1;
        logic signed [COEF_W-1:0] k2;
        logic signed [COEF_W-1:0] k3;
        logic signed [COEF_W-1:0] k4;
    } t_coefs;

    typedef struct packed {
        logic [STAGES-1:0] load;
    } t_pipe_en;

    typedef logic [255:0][CODE_W-1:0] t_lut;

    // Q30 fixed point helpers used to build the tables at elaboration
    localparam int Q_SHIFT = 30;
    localparam logic [63:0] Q_ONE  = 64'd1 << Q_SHIFT;
    localparam logic [63:0] Q_HALF = 64'd1 << (Q_SHIFT - 1);

    function automatic logic [63:0] f_qmul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + Q_HALF) >> Q_SHIFT;
    endfunction

    // x^2.4 in Q30
    function automatic logic [63:0] f_qpow_2p4(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        x2 = f_qmul(x, x);
        lo = 64'd0;
        hi = Q_ONE;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            p = f_qmul(mid, mid);
            p = f_qmul(p, mid);
            p = f_qmul(p, mid);
            p = f_qmul(p, mid);
            if (p <= x2) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return f_qmul(x2, lo);
    endfunction

    function automatic logic [CODE_W-1:0] f_q_to_code(input logic [63:0] q);
        logic [63:0] n;
        n = (64'd255 * q + Q_HALF) >> Q_SHIFT;
        return (n > 64'd255) ? 8'd255 : n[CODE_W-1:0];
    endfunction

    function automatic logic [CODE_W-1:0] f_to_linear(input logic [63:0] v);
        logic [63:0] t;
        logic [63:0] n;
        if (v <= 64'd10) begin
            n = (v * 64'd200 + 64'd1292) / 64'd2584;
            return n[CODE_W-1:0];
        end
        t = ((v * 64'd1000 + 64'd14025) << Q_SHIFT) / 64'd269025;
        return f_q_to_code(f_qpow_2p4(t));
    endfunction

    function automatic logic [CODE_W-1:0] f_to_srgb(input logic [63:0] v);
        logic [63:0] lin;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] num;
        logic [63:0] s;
        if (v == 64'd0) begin
            return 8'd0;
        end
        lin = (v << Q_SHIFT) / 64'd255;
        lo = 64'd0;
        hi = Q_ONE;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            if (f_qpow_2p4(mid) <= lin) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        num = 64'd1055 * lo;
        s = (num < 64'd55 * Q_ONE) ? 64'd0 : (num - 64'd55 * Q_ONE) / 64'd1000;
        return f_q_to_code(s);
    endfunction

    function automatic t_lut f_build_to_linear();
        t_lut tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = f_to_linear(64'(i));
        end
        return tab;
    endfunction

    function automatic t_lut f_build_to_srgb();
        t_lut tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = f_to_srgb(64'(i));
        end
        return tab;
    endfunction

    localparam t_lut TO_LINEAR = f_build_to_linear();
    localparam t_lut TO_SRGB   = f_build_to_srgb();

endpackage

[hw/rtl/apc_pipe_ctrl.sv]
// Valid tracking and per-stage load enables for the composite pipeline.
module apc_pipe_ctrl import apc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    output logic     o_valid,
    input  logic     i_ready,
    output t_pipe_en o_en
);

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] rdy;
    logic [STAGES-1:0] up_vld;

    // A stage can take new data when empty or when its content moves on
    always_comb begin
        rdy[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign up_vld = {r_vld[STAGES-2:0], i_valid};

    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            n_vld[k]       = rdy[k] ? up_vld[k] : r_vld[k];
            o_en.load[k]   = rdy[k] && up_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[STAGES-1];

    // Requests in flight change only by acceptances on either side
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> $countones(r_vld) == $countones($past(r_vld))
                     + $past(i_valid && o_ready) - $past(o_valid && i_ready))
        else $error("pipeline request count mismatch");

    // A full pipeline with a stalled output must refuse input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == {STAGES{1'b1}} && !i_ready) |-> !o_ready)
        else $error("input taken while pipeline full");

    // A stage never loads from an empty predecessor
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_en.load[STAGES-1:1] & ~r_vld[STAGES-2:0]) == '0)
        else $error("stage loaded from empty stage");

endmodule

[hw/rtl/apc_lane.sv]
// One channel lane: optional linearization and the k1*a*b + k2*a + k3*b + k4 sum.
module apc_lane import apc_pkg::*; (
    input  logic              i_clk,
    input  t_pipe_en          i_en,
    input  t_coefs            i_coef,
    input  logic              i_use_lut,
    input  logic [CODE_W-1:0] i_a,
    input  logic [CODE_W-1:0] i_b,
    output logic [CODE_W-1:0] o_code
);

    // Stage 1: mapped codes
    logic [CODE_W-1:0] r_a1, r_b1;
    // Stage 2: first products
    logic signed [PA_W-1:0] r_pa;
    logic signed [S1_W-1:0] r_s1;
    logic [CODE_W-1:0]      r_b2;
    // Stage 3: k1*a*b and 255*(k2*a + k3*b + 255*k4)
    logic signed [M_W-1:0]  r_m;
    logic signed [L_W-1:0]  r_l;
    // Stage 4: clamped quotient
    logic [CODE_W-1:0]      r_q;

    logic signed [CODE_W:0]  a_s, b_s, b2_s;
    logic signed [PA_W-1:0]  n_pa;
    logic signed [S1_W-1:0]  n_s1;
    logic signed [M_W-1:0]   n_m;
    logic signed [K4_W-1:0]  k4_255;
    logic signed [L1_W-1:0]  lin_sum;
    logic signed [L_W-1:0]   n_l;
    logic signed [NUM_W-1:0] num;
    logic [T_W-1:0]          t;
    logic [15:0]             t16;
    logic [15:0]             div;
    logic [CODE_W-1:0]       n_q;

    always_ff @(posedge i_clk) begin
        if (i_en.load[0]) begin
            r_a1 <= i_use_lut ? TO_LINEAR[i_a] : i_a;
            r_b1 <= i_use_lut ? TO_LINEAR[i_b] : i_b;
        end
    end

    assign a_s = signed'({1'b0, r_a1});
    assign b_s = signed'({1'b0, r_b1});

    always_comb begin
        n_pa = PA_W'(i_coef.k1) * PA_W'(a_s);
        n_s1 = S1_W'(i_coef.k2) * S1_W'(a_s) + S1_W'(i_coef.k3) * S1_W'(b_s);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load[1]) begin
            r_pa <= n_pa;
            r_s1 <= n_s1;
            r_b2 <= r_b1;
        end
    end

    assign b2_s = signed'({1'b0, r_b2});

    // x*255 as (x << 8) - x
    always_comb begin
        n_m     = M_W'(r_pa) * M_W'(b2_s);
        k4_255  = (K4_W'(i_coef.k4) <<< CODE_W) - K4_W'(i_coef.k4);
        lin_sum = L1_W'(r_s1) + L1_W'(k4_255);
        n_l     = (L_W'(lin_sum) <<< CODE_W) - L_W'(lin_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load[2]) begin
            r_m <= n_m;
            r_l <= n_l;
        end
    end

    // floor(num / (255 * 2^F)): shift out the fraction, then divide by 255
    always_comb begin
        num = NUM_W'(r_m) + NUM_W'(r_l);
        t   = num[NUM_W-2:COEF_FRAC_BITS];
        t16 = t[15:0];
        div = t16 + 16'd1 + (t16 >> CODE_W);
        if (num[NUM_W-1]) begin
            n_q = '0;
        end else if (t >= T_W'(SAT_T)) begin
            n_q = '1;
        end else begin
            n_q = div[15:CODE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load[3]) begin
            r_q <= n_q;
        end
    end

    assign o_code = r_q;

endmodule

[hw/rtl/apc_merge.sv]
// Output stage: gamma encoding of color lanes in linear mode and packing into one ARGB word.
module apc_merge import apc_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic                         i_linear,
    input  logic [LANES-1:0][CODE_W-1:0] i_code,
    output logic [PIXEL_W-1:0]           o_pixel
);

    logic [LANES-1:0][CODE_W-1:0] n_pix;
    logic [LANES-1:0][CODE_W-1:0] r_pix;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (i_linear && (i != ALPHA_LANE)) begin
                n_pix[i] = TO_SRGB[i_code[i]];
            end else begin
                n_pix[i] = i_code[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pix <= n_pix;
        end
    end

    assign o_pixel = r_pix;

endmodule

[hw/rtl/arithmetic_pixel_composite_top.sv]
// Top level of the arithmetic pixel composite: config registers, lanes and output merge.
// Pipeline: the map register loads at the accepting edge, then the mult 1, mult 2,
//   sum/divide and output registers follow before o_valid; only an output stall delays it.
// Throughput: one pixel pair per cycle unless the output stalls; four channel lanes run
//   in parallel and every stage is a single pipeline register with its own load enable.
// Reset: synchronous, active low; clears valid bits and all config registers
//   (coefficients zero, linear mode off). Tables are constants: no init pass.
module arithmetic_pixel_composite_top import apc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel request channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [PIXEL_W-1:0]   i_pixel_first,
    input  logic [PIXEL_W-1:0]   i_pixel_second,
    // result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [PIXEL_W-1:0]   o_pixel_out,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data
);

    t_coefs   r_coef;
    logic     r_linear;
    t_pipe_en pipe_en;

    logic [LANES-1:0][CODE_W-1:0] lane_a;
    logic [LANES-1:0][CODE_W-1:0] lane_b;
    logic [LANES-1:0][CODE_W-1:0] lane_code;

    // Config writes are always taken; unknown indexes are dropped.
    // Software must only write while the pipeline is empty (the block does not enforce this), so lanes read these live.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef   <= '0;
            r_linear <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_COEF_PRODUCT: r_coef.k1 <= i_cfg_data;
                REG_COEF_FIRST:   r_coef.k2 <= i_cfg_data;
                REG_COEF_SECOND:  r_coef.k3 <= i_cfg_data;
                REG_COEF_OFFSET:  r_coef.k4 <= i_cfg_data;
                REG_LINEAR_MODE:  r_linear  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake and stage enables; each stage advances when downstream has room
    apc_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_en    (pipe_en)
    );

    assign lane_a = i_pixel_first;
    assign lane_b = i_pixel_second;

    // One lane per channel; lane 0 is blue, alpha never goes through the tables
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        apc_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (pipe_en),
            .i_coef    (r_coef),
            .i_use_lut (r_linear && (g != ALPHA_LANE)),
            .i_a       (lane_a[g]),
            .i_b       (lane_b[g]),
            .o_code    (lane_code[g])
        );
    end

    // Merge: gamma-encode color lanes in linear mode and register the packed result
    apc_merge u_merge (
        .i_clk    (i_clk),
        .i_load   (pipe_en.load[STAGES-1]),
        .i_linear (r_linear),
        .i_code   (lane_code),
        .o_pixel  (o_pixel_out)
    );

endmodule
